>>> src/key_matrix_debounce_scanner_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the key matrix debounce scanner
// Implication checks that drop out when NO_ASSERTIONS is defined.
// ---------------------------------------------------------------------------
`ifndef KEY_MATRIX_DEBOUNCE_SCANNER_ASSERT_SVH
`define KEY_MATRIX_DEBOUNCE_SCANNER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define KMDS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kmds check failed");
// next-cycle implication
`define KMDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kmds check failed");
`else
`define KMDS_ASSERT_NOW(label, clk, rst, ante, cons)
`define KMDS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> src/kmds_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kmds_pkg
// Shared constants for the key matrix debounce scanner.
// ---------------------------------------------------------------------------
package kmds_pkg;

   localparam int ROWS      = 3;
   localparam int COLUMNS   = 6;
   localparam int DEDICATED = 2;
   localparam int KEY_TOTAL = ROWS * COLUMNS + DEDICATED;
   localparam int KEY_W     = $clog2(KEY_TOTAL + 1);

   localparam int COL_W  = 6;
   localparam int DED_W  = 2;
   localparam int VEC_W  = 20;
   localparam int ROW_W  = 2;
   localparam int DB_W   = 3;
   localparam int CNT_W  = 4;
   localparam int HOLD_W = 16;
   localparam int CSR_W  = 16;

   localparam logic [DB_W-1:0]   DEBOUNCE_RESET = 3'd4;
   localparam logic [HOLD_W-1:0] HOLD_RESET     = 16'd1000;

   localparam logic CSR_DEBOUNCE_LIMIT = 1'b0;
   localparam logic CSR_HOLD_LIMIT     = 1'b1;

endpackage

>>> src/key_matrix_debounce_scanner.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// key_matrix_debounce_scanner
// Row scanner with per-key up/down debounce counters and hold detection.
// ---------------------------------------------------------------------------
//  channel  | ports                                        | dir
//  req      | req_valid/ready, column/dedicated levels, takes | in
//  rsp      | rsp_valid/ready, key_bits, events, row_drive | out
//  csr      | csr_we, csr_index, csr_wdata                 | in
//
//  A scan tick item runs a capture, one update per key through the shared
//  debounce/hold update unit (20 keys) and a result register load before the
//  next item is accepted. The finish step waits while an earlier result is
//  still held on rsp. Reset is synchronous: all counters, key state and
//  latches clear at once. csr writes land immediately; the user must issue
//  them only while the block is idle; the block itself does not enforce it.
`include "key_matrix_debounce_scanner_assert.svh"

module key_matrix_debounce_scanner (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [kmds_pkg::COL_W-1:0]   req_column_levels,
   input  logic [kmds_pkg::DED_W-1:0]   req_dedicated_levels,
   input  logic                         req_take_pressed,
   input  logic                         req_take_held,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [kmds_pkg::VEC_W-1:0]   rsp_key_bits,
   output logic [kmds_pkg::VEC_W-1:0]   rsp_pressed_events,
   output logic [kmds_pkg::VEC_W-1:0]   rsp_held_events,
   output logic [kmds_pkg::ROW_W-1:0]   rsp_row_drive,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [kmds_pkg::CSR_W-1:0]   csr_wdata
);
   import kmds_pkg::*;

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [KEY_W-1:0] key_ff, key_in;

   // config
   logic [DB_W-1:0]   db_limit_ff, db_limit_in;
   logic [HOLD_W-1:0] hold_limit_ff, hold_limit_in;

   // scan state
   logic [ROW_W-1:0] scan_row_ff, scan_row_in;
   logic [CNT_W-1:0] db_cnt_ff [KEY_TOTAL];
   logic [CNT_W-1:0] db_cnt_in [KEY_TOTAL];
   logic [HOLD_W-1:0] hold_cnt_ff [KEY_TOTAL];
   logic [HOLD_W-1:0] hold_cnt_in [KEY_TOTAL];
   logic [VEC_W-1:0] key_state_ff, key_state_in;
   logic [VEC_W-1:0] press_latch_ff, press_latch_in;
   logic [VEC_W-1:0] held_latch_ff, held_latch_in;

   // captured tick
   logic [COL_W-1:0] cols_ff, cols_in;
   logic [DED_W-1:0] ded_ff, ded_in;
   logic             take_p_ff, take_p_in;
   logic             take_h_ff, take_h_in;
   logic [KEY_W-1:0] base_ff, base_in;   // first key of the sampled row
   logic             wrap_ff, wrap_in;   // dedicated buttons sampled

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [VEC_W-1:0] rsp_keys_ff, rsp_keys_in;
   logic [VEC_W-1:0] rsp_press_ff, rsp_press_in;
   logic [VEC_W-1:0] rsp_held_ff, rsp_held_in;
   logic [ROW_W-1:0] rsp_row_ff, rsp_row_in;

   // shared update unit
   logic [KEY_W-1:0]  col_off, ded_off;
   logic              sampled, pressed;
   logic signed [4:0] d_cur, d_step, lim_s;
   logic [CNT_W-1:0]  d_new;
   logic              old_bit, new_bit;
   logic [HOLD_W-1:0] h_cur, h_inc, h_new;
   logic              held_hit;
   logic [ROW_W-1:0]  row_eff;
   logic              fire;

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_key_bits       = rsp_keys_ff;
   assign rsp_pressed_events = rsp_press_ff;
   assign rsp_held_events    = rsp_held_ff;
   assign rsp_row_drive      = rsp_row_ff;

   assign row_eff = (32'(scan_row_ff) < ROWS) ? scan_row_ff : '0;
   assign fire    = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // per-key debounce step and hold count for the key under the walk pointer
   always_comb begin
      col_off  = key_ff - base_ff;
      ded_off  = key_ff - KEY_W'(ROWS * COLUMNS);
      sampled  = 1'b0;
      pressed  = 1'b0;
      if ((key_ff >= base_ff) && (32'(col_off) < COLUMNS)) begin
         sampled = 1'b1;
         pressed = ~cols_ff[col_off[2:0]];
      end else if (wrap_ff && (32'(key_ff) >= ROWS * COLUMNS)) begin
         sampled = 1'b1;
         pressed = ~ded_ff[ded_off[0]];
      end

      old_bit = key_state_ff[key_ff];
      new_bit = old_bit;
      d_cur   = {db_cnt_ff[key_ff][CNT_W-1], db_cnt_ff[key_ff]};
      lim_s   = {2'b00, db_limit_ff};
      d_step  = d_cur;
      if (sampled) begin
         if (pressed) begin
            d_step = d_cur + 5'sd1;
            if (d_step >= lim_s) begin
               d_step  = lim_s;
               new_bit = 1'b1;
            end
         end else begin
            d_step = d_cur - 5'sd1;
            if (d_step <= -lim_s) begin
               d_step  = -lim_s;
               new_bit = 1'b0;
            end
         end
      end
      d_new = d_step[CNT_W-1:0];

      h_cur    = hold_cnt_ff[key_ff];
      h_inc    = h_cur + 16'd1;
      h_new    = '0;
      held_hit = 1'b0;
      if (new_bit) begin
         h_new = h_cur;
         if (h_cur < hold_limit_ff) begin
            h_new    = h_inc;
            held_hit = (h_inc == hold_limit_ff);
         end
      end
   end

   // sequencer and state updates
   always_comb begin
      state_in       = state_ff;
      key_in         = key_ff;
      db_limit_in    = db_limit_ff;
      hold_limit_in  = hold_limit_ff;
      scan_row_in    = scan_row_ff;
      db_cnt_in      = db_cnt_ff;
      hold_cnt_in    = hold_cnt_ff;
      key_state_in   = key_state_ff;
      press_latch_in = press_latch_ff;
      held_latch_in  = held_latch_ff;
      cols_in        = cols_ff;
      ded_in         = ded_ff;
      take_p_in      = take_p_ff;
      take_h_in      = take_h_ff;
      base_in        = base_ff;
      wrap_in        = wrap_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_keys_in    = rsp_keys_ff;
      rsp_press_in   = rsp_press_ff;
      rsp_held_in    = rsp_held_ff;
      rsp_row_in     = rsp_row_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_DEBOUNCE_LIMIT: db_limit_in   = csr_wdata[DB_W-1:0];
            CSR_HOLD_LIMIT:     hold_limit_in = csr_wdata[HOLD_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready)
         rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cols_in   = req_column_levels;
               ded_in    = req_dedicated_levels;
               take_p_in = req_take_pressed;
               take_h_in = req_take_held;
               base_in   = KEY_W'(32'(row_eff) * COLUMNS);
               wrap_in   = (32'(row_eff) == ROWS - 1);
               if (32'(row_eff) == ROWS - 1)
                  scan_row_in = '0;
               else
                  scan_row_in = row_eff + 2'd1;
               key_in   = '0;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            db_cnt_in[key_ff]      = d_new;
            hold_cnt_in[key_ff]    = h_new;
            key_state_in[key_ff]   = new_bit;
            press_latch_in[key_ff] = press_latch_ff[key_ff] | (new_bit & ~old_bit);
            held_latch_in[key_ff]  = held_latch_ff[key_ff] | held_hit;
            if (32'(key_ff) == KEY_TOTAL - 1)
               state_in = ST_DONE;
            else
               key_in = key_ff + 1'b1;
         end
         ST_DONE: begin
            if (fire) begin
               rsp_valid_in = 1'b1;
               rsp_keys_in  = key_state_ff;
               rsp_press_in = take_p_ff ? press_latch_ff : '0;
               rsp_held_in  = take_h_ff ? held_latch_ff : '0;
               rsp_row_in   = scan_row_ff;
               if (take_p_ff)
                  press_latch_in = '0;
               if (take_h_ff)
                  held_latch_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         key_ff         <= '0;
         db_limit_ff    <= DEBOUNCE_RESET;
         hold_limit_ff  <= HOLD_RESET;
         scan_row_ff    <= '0;
         for (int i = 0; i < KEY_TOTAL; i++) begin
            db_cnt_ff[i]   <= '0;
            hold_cnt_ff[i] <= '0;
         end
         key_state_ff   <= '0;
         press_latch_ff <= '0;
         held_latch_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         key_ff         <= key_in;
         db_limit_ff    <= db_limit_in;
         hold_limit_ff  <= hold_limit_in;
         scan_row_ff    <= scan_row_in;
         db_cnt_ff      <= db_cnt_in;
         hold_cnt_ff    <= hold_cnt_in;
         key_state_ff   <= key_state_in;
         press_latch_ff <= press_latch_in;
         held_latch_ff  <= held_latch_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // captured tick and result payload
   always_ff @(posedge clock) begin
      cols_ff      <= cols_in;
      ded_ff       <= ded_in;
      take_p_ff    <= take_p_in;
      take_h_ff    <= take_h_in;
      base_ff      <= base_in;
      wrap_ff      <= wrap_in;
      rsp_keys_ff  <= rsp_keys_in;
      rsp_press_ff <= rsp_press_in;
      rsp_held_ff  <= rsp_held_in;
      rsp_row_ff   <= rsp_row_in;
   end

   `KMDS_ASSERT_NEXT(a_accept_starts_walk, clock, reset, req_valid && req_ready, state_ff == ST_WALK && key_ff == '0)
   `KMDS_ASSERT_NOW(a_walk_in_range, clock, reset, state_ff == ST_WALK, 32'(key_ff) < KEY_TOTAL)
   `KMDS_ASSERT_NEXT(a_take_clears_press, clock, reset, fire && take_p_ff, press_latch_ff == '0 && rsp_valid_ff)
   `KMDS_ASSERT_NEXT(a_take_clears_held, clock, reset, fire && take_h_ff, held_latch_ff == '0)

endmodule

>>> sim/tb_key_matrix_debounce_scanner.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_key_matrix_debounce_scanner
// Self-checking bench for the key matrix scanner: scan ticks are sent over
// the req channel, a scoreboard model predicts every rsp item and a checker
// compares them field by field, with random idling on both channels.
// ---------------------------------------------------------------------------
module tb_key_matrix_debounce_scanner;
   import kmds_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int STALL_LIMIT  = 3000;  // cycles with no handshake at all
   localparam int SETTLE_TICKS = 8;     // quiet time after the last rsp item
   localparam int MAX_REPORTS  = 10;
   localparam int PHASE_TICKS  = 140;

   // one predicted rsp item
   typedef struct packed {
      logic [VEC_W-1:0] key_bits;
      logic [VEC_W-1:0] pressed;
      logic [VEC_W-1:0] held;
      logic [ROW_W-1:0] row;
   } scan_result_type;

   // DUT ports; the driven inputs are all known from time zero
   logic               clock                = 1'b0;
   logic               reset                = 1'b1;
   logic               req_valid            = 1'b0;
   logic               req_ready;
   logic [COL_W-1:0]   req_column_levels    = '1;
   logic [DED_W-1:0]   req_dedicated_levels = '1;
   logic               req_take_pressed     = 1'b0;
   logic               req_take_held        = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready            = 1'b0;
   logic [VEC_W-1:0]   rsp_key_bits;
   logic [VEC_W-1:0]   rsp_pressed_events;
   logic [VEC_W-1:0]   rsp_held_events;
   logic [ROW_W-1:0]   rsp_row_drive;
   logic               csr_we               = 1'b0;
   logic               csr_index            = CSR_DEBOUNCE_LIMIT;
   logic [CSR_W-1:0]   csr_wdata            = '0;

   // Scoreboard model state: mirrors the block's counters and latches.
   int               db_count   [VEC_W];
   int               hold_ticks [VEC_W];
   logic [VEC_W-1:0] debounced;
   logic [VEC_W-1:0] press_lat;
   logic [VEC_W-1:0] held_lat;
   int               scan_row_m;
   int               db_lim;
   int               hold_lim;

   scan_result_type  due_scans[$];   // predictions waiting for their rsp item
   int               mismatches  = 0;
   bit               idling      = 1'b1;
   int               stall_left  = 0;
   int               quiet_cycles = 0;
   logic [VEC_W-1:0] finger_down = '0; // keys the virtual user is holding

   key_matrix_debounce_scanner u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_column_levels    (req_column_levels),
      .req_dedicated_levels (req_dedicated_levels),
      .req_take_pressed     (req_take_pressed),
      .req_take_held        (req_take_held),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_key_bits         (rsp_key_bits),
      .rsp_pressed_events   (rsp_pressed_events),
      .rsp_held_events      (rsp_held_events),
      .rsp_row_drive        (rsp_row_drive),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // -----------------------------------------------------------------------
   // Scoreboard model
   // -----------------------------------------------------------------------

   // One sample of one key: counter moves a step toward the sampled level and
   // clamps at +/- limit. Reaching the clamp records press or release. A limit
   // that was lowered under the counter gets clamped by the next step in the same direction.
   function automatic void debounce_step(input int k, input bit pressed);
      int d;
      d = db_count[k];
      if (pressed) begin
         d = d + 1;
         if (d >= db_lim) begin
            d = db_lim;
            debounced[k] = 1'b1;
         end
      end else begin
         d = d - 1;
         if (d <= -db_lim) begin
            d = -db_lim;
            debounced[k] = 1'b0;
         end
      end
      db_count[k] = d;
   endfunction

   // Full scan tick: sample the driven row, advance the row, sample the
   // dedicated buttons on wrap, then hold counters and latches.
   function automatic scan_result_type compute_scan(input logic [COL_W-1:0] cols,
                                                    input logic [DED_W-1:0] ded,
                                                    input logic tp,
                                                    input logic th);
      scan_result_type  r;
      logic [VEC_W-1:0] prev;
      int               row;
      prev = debounced;
      row  = (scan_row_m < ROWS) ? scan_row_m : 0;
      for (int c = 0; c < COLUMNS; c++)
         debounce_step(COLUMNS * row + c, !cols[c]);
      row++;
      if (row >= ROWS) begin
         row = 0;
         for (int b = 0; b < DEDICATED; b++)
            debounce_step(ROWS * COLUMNS + b, !ded[b]);
      end
      scan_row_m = row;
      // hold counter saturates at the limit and fires once; a zero limit
      // never fires since the count can never climb to it
      for (int k = 0; k < VEC_W; k++) begin
         if (debounced[k]) begin
            if (hold_ticks[k] < hold_lim) begin
               hold_ticks[k]++;
               if (hold_ticks[k] == hold_lim)
                  held_lat[k] = 1'b1;
            end
         end else begin
            hold_ticks[k] = 0;
         end
      end
      press_lat |= debounced & ~prev;
      // latches go out with this tick's events included, then clear if taken
      r.key_bits = debounced;
      r.pressed  = tp ? press_lat : '0;
      r.held     = th ? held_lat : '0;
      r.row      = scan_row_m[ROW_W-1:0];
      if (tp)
         press_lat = '0;
      if (th)
         held_lat = '0;
      return r;
   endfunction

   // -----------------------------------------------------------------------
   // Channel helpers
   // -----------------------------------------------------------------------

   // Sends one scan tick; returns at the edge where it was accepted.
   task automatic send_tick(input logic [COL_W-1:0] cols, input logic [DED_W-1:0] ded,
                            input logic tp, input logic th);
      int gap;
      gap = 0;
      if (idling && $urandom_range(0, 99) < 15)
         gap = $urandom_range(1, 30);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      due_scans.push_back(compute_scan(cols, ded, tp, th));
      req_valid            <= 1'b1;
      req_column_levels    <= cols;
      req_dedicated_levels <= ded;
      req_take_pressed     <= tp;
      req_take_held        <= th;
      do @(posedge clock); while (!req_ready);
   endtask

   // Sender stops and waits until every predicted item came back.
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (due_scans.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input int unsigned value);
      wait_for_idle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_DEBOUNCE_LIMIT)
         db_lim = value & 32'h7;
      else
         hold_lim = value & 32'hFFFF;
   endtask

   // -----------------------------------------------------------------------
   // Tests
   // -----------------------------------------------------------------------

   // Everything released after reset: all fields zero, row walks 1,2,0.
   task automatic test_idle_scan();
      repeat (3) send_tick('1, '1, 1'b1, 1'b1);
   endtask

   // Every key pressed at once with the reset debounce limit: four passes
   // are needed before all twenty bits come up.
   task automatic test_full_press();
      for (int i = 0; i < 12; i++)
         send_tick('0, '0, (i % 4) == 3, i == 11);
   endtask

   // Limits dropped under live counters: debounce counters clamp on the next
   // press sample, hold counts already at or above the limit neither count nor fire.
   task automatic test_lowered_limits();
      write_reg(CSR_DEBOUNCE_LIMIT, 1);
      write_reg(CSR_HOLD_LIMIT, 1);
      for (int i = 0; i < 3; i++)
         send_tick('0, '0, 1'b0, i == 2);
      for (int i = 0; i < 3; i++)
         send_tick('1, '1, i == 2, 1'b1);
   endtask

   // Zero debounce limit records on the spot; zero hold limit never fires.
   task automatic test_zero_limits();
      write_reg(CSR_DEBOUNCE_LIMIT, 0);
      write_reg(CSR_HOLD_LIMIT, 0);
      send_tick(6'h2A, 2'b01, 1'b1, 1'b0);
      send_tick(6'h15, 2'b10, 1'b0, 1'b1);
      send_tick(6'h2A, 2'b01, 1'b1, 1'b1);
      send_tick(6'h15, 2'b10, 1'b1, 1'b1);
   endtask

   // Virtual typing: keys go down and up now and then, the driven row shows
   // the held keys with some contact bounce, and a few ticks carry garbage.
   task automatic test_random_typing(input int n_ticks);
      logic [COL_W-1:0] cols;
      logic [DED_W-1:0] ded;
      int               row;
      for (int i = 0; i < n_ticks; i++) begin
         if ($urandom_range(0, 99) < 6)
            finger_down[$urandom_range(0, VEC_W - 1)] ^= 1'b1;
         row = scan_row_m;
         if ($urandom_range(0, 9) == 0) begin
            cols = COL_W'($urandom);
            ded  = DED_W'($urandom);
         end else begin
            for (int c = 0; c < COLUMNS; c++)
               cols[c] = ~finger_down[COLUMNS * row + c] ^ ($urandom_range(0, 99) < 4);
            for (int b = 0; b < DEDICATED; b++)
               ded[b] = ~finger_down[ROWS * COLUMNS + b] ^ ($urandom_range(0, 99) < 4);
         end
         send_tick(cols, ded, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
      end
   endtask

   // Phases over several settings, extremes included; one phase runs with
   // no idling on either side.
   task automatic test_setting_sweep();
      int unsigned db_set   [8] = '{1, 3, 7, 2, 5, 0, 7, 4};
      int unsigned hold_set [8] = '{3, 12, 40, 0, 65535, 1, 25, 9};
      for (int p = 0; p < 8; p++) begin
         if (p == 7) begin
            db_set[p]   = $urandom_range(0, 7);
            hold_set[p] = $urandom_range(1, 60);
         end
         write_reg(CSR_DEBOUNCE_LIMIT, db_set[p]);
         write_reg(CSR_HOLD_LIMIT, hold_set[p]);
         idling = (p != 2);
         test_random_typing(PHASE_TICKS);
      end
      idling = 1'b1;
   endtask

   // -----------------------------------------------------------------------
   // Receiver: ready mostly high, with occasional short stalls
   // -----------------------------------------------------------------------
   always @(posedge clock) begin
      if (!idling) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if ($urandom_range(0, 99) < 2) begin
         stall_left <= $urandom_range(0, 7);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Checker: every accepted rsp item against the oldest prediction.
   always @(posedge clock) begin : check_results
      scan_result_type got;
      scan_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_key_bits, rsp_pressed_events, rsp_held_events, rsp_row_drive};
         if (due_scans.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: rsp item with nothing predicted: keys %h row %0d",
                        $realtime, got.key_bits, got.row);
         end else begin
            want = due_scans.pop_front();
            if (got.key_bits !== want.key_bits || got.pressed !== want.pressed ||
                got.held !== want.held || got.row !== want.row) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: rsp mismatch exp keys %h prs %h held %h row %0d, got %h %h %h %0d",
                           $realtime, want.key_bits, want.pressed, want.held, want.row,
                           got.key_bits, got.pressed, got.held, got.row);
            end
         end
      end
   end

   // Watchdog: too long without any handshake means the block is stuck.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      // model starts from the reset state
      scan_row_m = 0;
      db_lim     = int'(DEBOUNCE_RESET);
      hold_lim   = int'(HOLD_RESET);
      debounced  = '0;
      press_lat  = '0;
      held_lat   = '0;
      for (int k = 0; k < VEC_W; k++) begin
         db_count[k]   = 0;
         hold_ticks[k] = 0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_idle_scan();
      test_full_press();
      test_lowered_limits();
      test_zero_limits();
      test_setting_sweep();

      wait_for_idle();
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
